/* sv/tff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tff_pkg
// Shared types and constants for the TLV field finder: result kinds, the
// result record and the per-byte push bundle from parser to result queue.
// ----------------------------------------------------------------------------
package tff_pkg;

  localparam int unsigned OFFSET_W          = 20;
  localparam int unsigned LEN_W             = 16;
  localparam int unsigned OFFSET_RANGE      = 1 << OFFSET_W;
  localparam int unsigned MAX_MESSAGE_BYTES = 1048576;
  localparam int unsigned RES_FIFO_DEPTH    = 4;
  localparam logic [3:0]  NIBBLE_MASK       = 4'h F;

  typedef enum logic [1:0] {
    KIND_MATCH     = 2'd0,
    KIND_END_OK    = 2'd1,
    KIND_END_NONE  = 2'd2,
    KIND_END_TRUNC = 2'd3
  } tff_kind_e;

  typedef struct packed {
    tff_kind_e           kind;
    logic [OFFSET_W-1:0] value_offset;
    logic [LEN_W-1:0]    value_length;
    logic                end_of_message;
  } tff_result_t;

  // Up to two results per byte: a match first, then the end status.
  typedef struct packed {
    logic        match_v;
    logic        end_v;
    tff_result_t match_r;
    tff_result_t end_r;
  } tff_push_t;

endpackage

/* sv/tff_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tff_parser
// Per-byte TLV header/value tracker. Updates the parse state for each
// accepted byte and emits at most a match record and an end status.
// ----------------------------------------------------------------------------
module tff_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = tff_pkg::MAX_MESSAGE_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               mode_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic [3:0]         sought_id_i,
  input  logic [3:0]         sought_type_i,
  output tff_pkg::tff_push_t push_o
);
  import tff_pkg::*;

  localparam int unsigned MSG_LIMIT =
    (MAX_MESSAGE_BYTES < OFFSET_RANGE) ? MAX_MESSAGE_BYTES : OFFSET_RANGE;
  // position saturates at the limit, so it must hold the limit itself
  localparam int unsigned POS_W = $clog2(MSG_LIMIT + 1);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_VALUE
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [7:0]          len_hi_q, len_hi_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [OFFSET_W-1:0] start_q, start_d;
  logic [LEN_W-1:0]    size_q, size_d;
  logic                match_q, match_d;
  logic                found_q, found_d;
  logic                ovf_q, ovf_d;

  logic                complete;
  logic                truncated;
  logic [LEN_W-1:0]    rem_dec;
  tff_kind_e           end_kind;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_hi_d  = len_hi_q;
    rem_d     = rem_q;
    start_d   = start_q;
    size_d    = size_q;
    match_d   = match_q;
    found_d   = found_q;
    ovf_d     = ovf_q;
    complete  = 1'b0;
    truncated = 1'b0;
    end_kind  = KIND_END_NONE;
    rem_dec   = rem_q - LEN_W'(1);
    push_o    = '0;

    if (accept_i) begin
      ovf_d = ovf_q | (pos_q >= POS_W'(MSG_LIMIT));
      if (!ovf_d) begin
        unique case (phase_q)
          PH_TAG: begin
            match_d = ((data_byte_i[7:4] & NIBBLE_MASK) == sought_id_i)
                    && ((data_byte_i[3:0] & NIBBLE_MASK) == sought_type_i);
            phase_d = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_hi_d = data_byte_i;
            phase_d  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            size_d  = {len_hi_q, data_byte_i};
            start_d = OFFSET_W'((OFFSET_W + 1)'(pos_q) + (OFFSET_W + 1)'(1));
            rem_d   = {len_hi_q, data_byte_i};
            if ({len_hi_q, data_byte_i} == '0) begin
              complete = 1'b1;
              phase_d  = PH_TAG;
            end else begin
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              complete = 1'b1;
              phase_d  = PH_TAG;
            end
          end
          default: phase_d = PH_TAG;
        endcase
        pos_d = pos_q + POS_W'(1);
      end

      // tag byte never completes, so match_d is settled here
      if (complete && match_d && (mode_i || !found_q)) begin
        push_o.match_v = 1'b1;
        push_o.match_r = '{KIND_MATCH, start_d, size_d, 1'b0};
        found_d        = 1'b1;
      end

      if (last_byte_i) begin
        truncated = (phase_d == PH_VALUE);
        if (ovf_d) begin
          end_kind = KIND_END_TRUNC;
        end else if (mode_i) begin
          end_kind = truncated ? KIND_END_TRUNC : KIND_END_OK;
        end else if (found_d) begin
          end_kind = KIND_END_OK;
        end else begin
          end_kind = truncated ? KIND_END_TRUNC : KIND_END_NONE;
        end
        push_o.end_v = 1'b1;
        push_o.end_r = '{end_kind, '0, '0, 1'b1};
        // fresh message
        phase_d  = PH_TAG;
        pos_d    = '0;
        len_hi_d = '0;
        rem_d    = '0;
        start_d  = '0;
        size_d   = '0;
        match_d  = 1'b0;
        found_d  = 1'b0;
        ovf_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      pos_q    <= '0;
      len_hi_q <= '0;
      rem_q    <= '0;
      start_q  <= '0;
      size_q   <= '0;
      match_q  <= 1'b0;
      found_q  <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_hi_q <= len_hi_d;
      rem_q    <= rem_d;
      start_q  <= start_d;
      size_q   <= size_d;
      match_q  <= match_d;
      found_q  <= found_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

/* sv/tff_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tff_result_fifo
// Small result queue. Takes up to two records per cycle (match, then end
// status) and hands out one record per output transfer.
// ----------------------------------------------------------------------------
module tff_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tff_pkg::tff_push_t   push_i,
  input  logic                 pop_i,
  output logic                 room_o,
  output logic                 valid_o,
  output tff_pkg::tff_result_t head_o
);
  import tff_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  tff_result_t      mem_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] end_addr;
  logic [1:0]       n_push;
  logic             pop;

  assign pop      = pop_i & valid_o;
  assign n_push   = {1'b0, push_i.match_v} + {1'b0, push_i.end_v};
  assign end_addr = wr_ptr_q + PTR_W'(push_i.match_v);
  assign wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign count_d  = count_q + CNT_W'(n_push) - CNT_W'(pop);

  // a byte may add two records, so keep two slots free
  assign room_o  = count_q <= CNT_W'(RES_FIFO_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.match_v) begin
      mem_q[wr_ptr_q] <= push_i.match_r;
    end
    if (push_i.end_v) begin
      mem_q[end_addr] <= push_i.end_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RES_FIFO_DEPTH))
    else $error("result queue count out of range");

  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.match_v || push_i.end_v) |-> room_o)
    else $error("result pushed without two free slots");

  a_count_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd0 && !pop) |=> $stable(count_q))
    else $error("result count moved with no push or pop");

  a_pointer_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

/* sv/tlv_field_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_field_finder
// Streaming TLV parser that locates records by field id and type code.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle (tag, 16-bit big-endian length, value)
// and reports matching records with their value offset and length, plus an
// end status on the last byte of each message. Each byte is handled in the
// cycle it is accepted; results go through a four-entry queue, so the input
// sustains one byte per clock while the output side keeps up. in_stall_o
// rises only when fewer than two queue slots are free, which happens only
// when the output is held off (the last byte of a message can add two
// records at once). Each result is registered in the queue before it is output.
module tlv_field_finder #(
  parameter int unsigned MAX_MESSAGE_BYTES = tff_pkg::MAX_MESSAGE_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  input  logic [3:0]                   sought_id_i,
  input  logic [3:0]                   sought_type_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [tff_pkg::OFFSET_W-1:0] value_offset_o,
  output logic [tff_pkg::LEN_W-1:0]    value_length_o,
  output logic                         end_of_message_o
);
  import tff_pkg::*;

  tff_push_t   push;
  tff_result_t head;
  logic        room;
  logic        accept;

  assign in_stall_o = ~room;
  assign accept     = in_valid_i & room;

  tff_parser #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .sought_id_i  (sought_id_i),
    .sought_type_i(sought_type_i),
    .push_o       (push)
  );

  tff_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (~out_stall_i),
    .room_o (room),
    .valid_o(out_valid_o),
    .head_o (head)
  );

  assign kind_o           = head.kind;
  assign value_offset_o   = head.value_offset;
  assign value_length_o   = head.value_length;
  assign end_of_message_o = head.end_of_message;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the TLV field finder.
// ----------------------------------------------------------------------------
// A queue-fed driver streams message bytes with random gaps. A monitor
// predicts match and end-status records for each byte transfer and checks
// every result transfer against them in order. The stimulus runs directed
// messages, a burst against a long output hold-off, and then random
// well-formed and broken messages.
module tb;
  import tff_pkg::*;

  localparam int unsigned MSG_LIMIT      = (MAX_MESSAGE_BYTES < OFFSET_RANGE) ?
                                           MAX_MESSAGE_BYTES : OFFSET_RANGE;
  localparam int unsigned QUEUE_FILL     = 64;
  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES   = 1600;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_VALUE
  } parse_phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
    logic [3:0] sid;
    logic [3:0] sty;
    logic [1:0] gap;
  } tlv_byte_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = 1'b0;
  logic [7:0]          data_byte = 8'h00;
  logic                last_byte = 1'b0;
  logic [3:0]          sought_id = 4'h0;
  logic [3:0]          sought_type = 4'h0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          kind;
  logic [OFFSET_W-1:0] value_offset;
  logic [LEN_W-1:0]    value_length;
  logic                end_of_message;

  tlv_field_finder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (mode),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .sought_id_i      (sought_id),
    .sought_type_i    (sought_type),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .value_offset_o   (value_offset),
    .value_length_o   (value_length),
    .end_of_message_o (end_of_message)
  );

  // Pending bytes and predicted result records
  tlv_byte_t   byte_queue[$];
  tff_result_t expected_records[$];
  logic [7:0]  msg_bytes[$];

  int unsigned bytes_pushed = 0;
  int unsigned bytes_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  tlv_byte_t   next_byte;
  logic        have_next = 1'b0;
  int unsigned gap_left = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  tff_result_t want_rec;

  // Parser state mirror
  parse_phase_e phase;
  logic [20:0]  byte_pos;
  logic [7:0]   len_hi;
  logic [15:0]  remaining;
  logic [19:0]  rec_start;
  logic [15:0]  rec_len;
  logic         tag_matches;
  logic         found;
  logic         overflow;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic clear_message_state();
    phase       = PH_TAG;
    byte_pos    = '0;
    len_hi      = '0;
    remaining   = '0;
    rec_start   = '0;
    rec_len     = '0;
    tag_matches = 1'b0;
    found       = 1'b0;
    overflow    = 1'b0;
  endtask

  initial clear_message_state();

  task automatic add_expected(input tff_result_t rec);
    expected_records = {expected_records, rec};
  endtask

  task automatic add_msg_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endtask

  task automatic parse_byte(input tlv_byte_t item);
    logic        complete;
    tff_result_t rec;
    complete = 1'b0;
    if (!overflow && byte_pos >= MSG_LIMIT) overflow = 1'b1;
    if (!overflow) begin
      case (phase)
        PH_TAG: begin
          tag_matches = (item.data[7:4] == item.sid) && (item.data[3:0] == item.sty);
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi = item.data;
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rec_len   = {len_hi, item.data};
          rec_start = byte_pos[19:0] + 20'd1;  // wraps at the offset range
          remaining = rec_len;
          if (remaining == 16'd0) begin
            complete = 1'b1;
            phase = PH_TAG;
          end else begin
            phase = PH_VALUE;
          end
        end
        default: begin
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            complete = 1'b1;
            phase = PH_TAG;
          end
        end
      endcase
      byte_pos = byte_pos + 21'd1;
    end

    if (complete && tag_matches && (item.mode || !found)) begin
      rec.kind           = KIND_MATCH;
      rec.value_offset   = rec_start;
      rec.value_length   = rec_len;
      rec.end_of_message = 1'b0;
      add_expected(rec);
      found = 1'b1;
    end

    if (item.last) begin
      if (overflow)
        rec.kind = KIND_END_TRUNC;
      else if (item.mode)
        rec.kind = (phase == PH_VALUE) ? KIND_END_TRUNC : KIND_END_OK;
      else if (found)
        rec.kind = KIND_END_OK;
      else
        rec.kind = (phase == PH_VALUE) ? KIND_END_TRUNC : KIND_END_NONE;
      rec.value_offset   = '0;
      rec.value_length   = '0;
      rec.end_of_message = 1'b1;
      add_expected(rec);
      clear_message_state();
    end
  endtask

  // Byte driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (!have_next && byte_queue.size() > 0) begin
        next_byte = byte_queue.pop_front();
        have_next = 1'b1;
        gap_left  = next_byte.gap;
      end
      if (have_next && gap_left == 0) begin
        in_valid    <= 1'b1;
        mode        <= next_byte.mode;
        data_byte   <= next_byte.data;
        last_byte   <= next_byte.last;
        sought_id   <= next_byte.sid;
        sought_type <= next_byte.sty;
        have_next = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (have_next) gap_left = gap_left - 1;
      end
    end
  end

  // Result receiver: random stalls plus one requested long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (out_fire) rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait = rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor and checker
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid && !in_stall;
    out_fire = rst_ni && out_valid && !out_stall;
    if (in_fire) begin
      parse_byte({mode, data_byte, last_byte, sought_id, sought_type, 2'd0});
      bytes_accepted = bytes_accepted + 1;
    end
    if (out_fire) begin
      if (expected_records.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result kind=%0d off=%0d len=%0d eom=%0d", $realtime,
                   kind, value_offset, value_length, end_of_message);
      end else begin
        want_rec = expected_records.pop_front();
        if (kind !== want_rec.kind || value_offset !== want_rec.value_offset ||
            value_length !== want_rec.value_length ||
            end_of_message !== want_rec.end_of_message) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT)
            $display({"%0t: mismatch exp kind=%0d off=%0d len=%0d eom=%0d,",
                      " got kind=%0d off=%0d len=%0d eom=%0d"},
                     $realtime, want_rec.kind, want_rec.value_offset,
                     want_rec.value_length, want_rec.end_of_message,
                     kind, value_offset, value_length, end_of_message);
        end
      end
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_byte(input logic m, input logic [7:0] b, input logic l,
                           input logic [3:0] sid, input logic [3:0] sty);
    tlv_byte_t item;
    while (byte_queue.size() >= QUEUE_FILL) @(posedge clk_i);
    item.mode = m;
    item.data = b;
    item.last = l;
    item.sid  = sid;
    item.sty  = sty;
    item.gap  = tx_idle_on ? 2'($urandom_range(0, 3)) : 2'd0;
    byte_queue = {byte_queue, item};
    bytes_pushed = bytes_pushed + 1;
  endtask

  task automatic add_header(input logic [7:0] tag, input logic [15:0] len);
    add_msg_byte(tag);
    add_msg_byte(len[15:8]);
    add_msg_byte(len[7:0]);
  endtask

  task automatic send_message(input logic m, input logic [3:0] sid, input logic [3:0] sty);
    int unsigned n;
    n = msg_bytes.size();
    for (int unsigned i = 0; i < n; i++)
      push_byte(m, msg_bytes[i], i == n - 1, sid, sty);
    msg_bytes.delete();
  endtask

  task automatic wait_quiet();
    while (bytes_accepted != bytes_pushed || expected_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned n;
    int unsigned len;
    logic        m;
    logic [3:0]  sid;
    logic [3:0]  sty;
    logic [7:0]  tag;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Mode 0: first match reported, a later match suppressed
    add_header(8'hFF, 16'd1);
    add_msg_byte(8'hAA);
    add_header(8'hFF, 16'd0);
    send_message(1'b0, 4'hF, 4'hF);
    // Mode 1: zero-length match, then a value cut off by the end
    add_header(8'h00, 16'd0);
    add_header(8'h00, 16'd2);
    add_msg_byte(8'h11);
    send_message(1'b1, 4'h0, 4'h0);
    // Partial header, nothing found
    add_msg_byte(8'h5A);
    add_msg_byte(8'h00);
    send_message(1'b0, 4'h5, 4'hA);
    // Mode 0 truncated without a match
    add_header(8'h12, 16'd3);
    add_msg_byte(8'h01);
    send_message(1'b0, 4'h1, 4'h2);
    // Single-byte message
    add_msg_byte(8'h34);
    send_message(1'b1, 4'h3, 4'h4);
    // Match and end status on the same byte
    add_header(8'h21, 16'd0);
    send_message(1'b1, 4'h2, 4'h1);
    wait_quiet();

    // Burst of back-to-back matches against a long output hold-off
    tx_idle_on = 1'b0;
    hold_req = hold_req + 1;
    repeat (12) add_header(8'h96, 16'd0);
    send_message(1'b1, 4'h9, 4'h6);
    wait_quiet();

    tx_idle_on = 1'b1;
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 7) == 0) rx_idle_on = !rx_idle_on;
      m   = 1'($urandom_range(0, 1));
      sid = 4'($urandom_range(0, 15));
      sty = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        // noise
        n = $urandom_range(1, 12);
        repeat (n) add_msg_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          tag = $urandom_range(0, 1) ? {sid, sty} : 8'($urandom_range(0, 255));
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
          add_header(tag, 16'(len));
          repeat (len) add_msg_byte(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 6))
          0: begin
            tag = $urandom_range(0, 1) ? {sid, sty} : 8'($urandom_range(0, 255));
            len = $urandom_range(1, 8);
            add_header(tag, 16'(len));
            repeat ($urandom_range(0, len - 1)) add_msg_byte(8'($urandom_range(0, 255)));
          end
          1: begin
            add_msg_byte($urandom_range(0, 1) ? {sid, sty} : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) add_msg_byte(8'($urandom_range(0, 255)));
          end
          default: ;
        endcase
        if (msg_bytes.size() == 0) add_msg_byte(8'($urandom_range(0, 255)));
      end
      random_sent = random_sent + msg_bytes.size();
      send_message(m, sid, sty);
    end
    wait_quiet();

    if (expected_records.size() != 0) fail_count = fail_count + 1;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* tlv_field_finder.f */
sv/tff_pkg.sv
sv/tff_parser.sv
sv/tff_result_fifo.sv
sv/tlv_field_finder.sv
tb/tb.sv
